// File: rtl/core/mphd_pkg.sv
// Shared types, codes and constants of the media packet header deframer.
package mphd_pkg;

	// Header layout
	localparam int unsigned HEADER_BYTES = 30;
	localparam int unsigned FIXED_PART   = 16;
	localparam int unsigned STAMP_END    = FIXED_PART + 8;
	localparam logic [31:0] MARK_WORD    = 32'h3031_6364;
	localparam logic [15:0] MAX_BODY_RESET = 16'd950;

	// Parse phases
	localparam logic [1:0] PH_HUNT   = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_BODY   = 2'd2;

	// Result kinds
	localparam logic [1:0] RES_HEADER = 2'd0;
	localparam logic [1:0] RES_BODY   = 2'd1;
	localparam logic [1:0] RES_ERROR  = 2'd2;

	// Media kinds
	localparam logic [2:0] MEDIA_VIDEO_B = 3'd2;
	localparam logic [2:0] MEDIA_AUDIO   = 3'd3;
	localparam logic [2:0] MEDIA_PASS    = 3'd4;

	// Fragment marks
	localparam logic [1:0] FRAG_ATOMIC = 2'd0;
	localparam logic [1:0] FRAG_LAST   = 2'd2;

	// Error codes
	localparam logic [2:0] ERR_MARK     = 3'd0;
	localparam logic [2:0] ERR_PAYLOAD  = 3'd1;
	localparam logic [2:0] ERR_DATATYPE = 3'd2;
	localparam logic [2:0] ERR_SUBPACK  = 3'd3;
	localparam logic [2:0] ERR_LENGTH   = 3'd4;

	// Header byte positions
	localparam logic [4:0] POS_PTYPE   = 5'd5;
	localparam logic [4:0] POS_SEQ_HI  = 5'd6;
	localparam logic [4:0] POS_SEQ_LO  = 5'd7;
	localparam logic [4:0] POS_SIM_LO  = 5'd8;
	localparam logic [4:0] POS_SIM_HI  = 5'd13;
	localparam logic [4:0] POS_CHANNEL = 5'd14;
	localparam logic [4:0] POS_TYPE    = 5'd15;
	localparam logic [4:0] POS_LEN_VIDEO = 5'(HEADER_BYTES - 2);
	localparam logic [4:0] POS_LEN_AUDIO = 5'(HEADER_BYTES - 6);
	localparam logic [4:0] POS_LEN_PASS  = 5'(HEADER_BYTES - 14);

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [15:0] sequence_number;
		logic [7:0]  channel_number;
		logic [47:0] sim_number;
		logic [2:0]  media_kind;
		logic [1:0]  fragment_mark;
		logic [2:0]  codec_kind;
		logic [63:0] time_stamp;
		logic [15:0] body_length;
		logic [7:0]  body_byte;
		logic        message_end;
		logic [2:0]  error_code;
	} result_t;

	typedef struct packed {
		logic       known;
		logic [2:0] code;
	} codec_t;

	// Map the 7-bit payload type onto the codec code.
	function automatic codec_t codec_of(input logic [6:0] ptype);
		codec_t c;
		c.known = 1'b1;
		case (ptype)
			7'd6:    c.code = 3'd0;
			7'd7:    c.code = 3'd1;
			7'd19:   c.code = 3'd2;
			7'd26:   c.code = 3'd3;
			7'd98:   c.code = 3'd4;
			default: begin
				c.known = 1'b0;
				c.code  = 3'd0;
			end
		endcase
		return c;
	endfunction

endpackage

// File: rtl/core/media_packet_header_deframer.sv
// Top level of the media packet header deframer: byte parser and result register.
// Takes one stream byte per word and parses a media packet header: the mark
// 30 31 63 64, version/flags, marker bit and payload type, sequence number,
// six BCD SIM bytes, channel, and a data-type/subpackage byte, followed by
// an 8-byte timestamp, two frame intervals and the body length for video,
// the timestamp and body length for audio, or the body length alone for
// passthrough. On the last length byte one header summary word goes out,
// then one body word per body byte; message_end marks the final byte (or an
// empty-body summary) of an atomic or last subpackage. A bad mark (seen on
// the fourth byte), an unknown payload type, a bad data type, a bad
// subpackage mark or a body length above max_body_length produces a single
// error word and the parser returns to hunting for the next four-byte mark.
// Each input word is parsed in the cycle it is taken and its result lands in
// one output register, so the block takes one byte per clock; it stalls
// only while that output register holds a word the consumer has not taken.
// max_body_length is written through the cfg port (always ready); the user must write it only
// while idle, since the block itself does not enforce that. It resets to 950.
module media_packet_header_deframer (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] max_body_length,
	// byte input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_value,
	// result output
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [15:0] sequence_number,
	output logic [7:0]  channel_number,
	output logic [47:0] sim_number,
	output logic [2:0]  media_kind,
	output logic [1:0]  fragment_mark,
	output logic [2:0]  codec_kind,
	output logic [63:0] time_stamp,
	output logic [15:0] body_length,
	output logic [7:0]  body_byte,
	output logic        message_end,
	output logic [2:0]  error_code
);

	// Parser state
	logic [1:0]  phase_q,  phase_d;
	logic [4:0]  idx_q,    idx_d;
	logic [23:0] mark_q,   mark_d;
	logic [15:0] seq_q,    seq_d;
	logic [7:0]  chan_q,   chan_d;
	logic [47:0] sim_q,    sim_d;
	logic [2:0]  kind_q,   kind_d;
	logic [1:0]  frag_q,   frag_d;
	logic [2:0]  codec_q,  codec_d;
	logic [63:0] stamp_q,  stamp_d;
	logic [15:0] len_q,    len_d;
	logic [15:0] remain_q, remain_d;
	logic [15:0] max_len_q;

	// Output register
	mphd_pkg::result_t res_q, res_d;
	logic              out_valid_q;

	logic              accept;
	logic              emit;
	logic              is_error;
	logic              advance;
	logic              ends_msg;
	logic [31:0]       mark_full;
	logic [4:0]        hunt_idx;
	logic [4:0]        len_pos;
	logic [15:0]       len_full;
	mphd_pkg::codec_t  codec_sel;

	assign cfg_ready = 1'b1;
	// Take a byte whenever the result register is empty or drains this cycle.
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;

	assign ends_msg  = (frag_q == mphd_pkg::FRAG_ATOMIC) || (frag_q == mphd_pkg::FRAG_LAST);
	assign mark_full = {mark_q, byte_value};
	assign hunt_idx  = (idx_q > 5'd3) ? 5'd0 : idx_q;
	assign len_full  = {len_q[7:0], byte_value};
	assign codec_sel = mphd_pkg::codec_of(byte_value[6:0]);

	// Length bytes sit at a position set by the media kind.
	always_comb begin
		if (kind_q <= mphd_pkg::MEDIA_VIDEO_B) begin
			len_pos = mphd_pkg::POS_LEN_VIDEO;
		end else if (kind_q == mphd_pkg::MEDIA_AUDIO) begin
			len_pos = mphd_pkg::POS_LEN_AUDIO;
		end else begin
			len_pos = mphd_pkg::POS_LEN_PASS;
		end
	end

	// Next state and result for the byte on the input.
	always_comb begin
		phase_d  = phase_q;
		idx_d    = idx_q;
		mark_d   = mark_q;
		seq_d    = seq_q;
		chan_d   = chan_q;
		sim_d    = sim_q;
		kind_d   = kind_q;
		frag_d   = frag_q;
		codec_d  = codec_q;
		stamp_d  = stamp_q;
		len_d    = len_q;
		remain_d = remain_q;
		emit     = 1'b0;
		is_error = 1'b0;
		advance  = 1'b0;
		res_d    = '0;

		case (phase_q)
			mphd_pkg::PH_BODY: begin
				emit            = 1'b1;
				res_d.result_kind = mphd_pkg::RES_BODY;
				res_d.body_byte = byte_value;
				if (remain_q != 16'd0) begin
					remain_d = remain_q - 16'd1;
				end
				if (remain_d == 16'd0) begin
					res_d.message_end = ends_msg;
					phase_d = mphd_pkg::PH_HUNT;
					idx_d   = 5'd0;
					mark_d  = '0;
				end
			end
			mphd_pkg::PH_HEADER: begin
				advance = 1'b1;
				if (idx_q == mphd_pkg::POS_PTYPE) begin
					if (codec_sel.known) begin
						codec_d = codec_sel.code;
					end else begin
						is_error = 1'b1;
						res_d.error_code = mphd_pkg::ERR_PAYLOAD;
					end
				end else if (idx_q == mphd_pkg::POS_SEQ_HI || idx_q == mphd_pkg::POS_SEQ_LO) begin
					seq_d = {seq_q[7:0], byte_value};
				end else if (idx_q >= mphd_pkg::POS_SIM_LO && idx_q <= mphd_pkg::POS_SIM_HI) begin
					sim_d = {sim_q[39:0], byte_value};
				end else if (idx_q == mphd_pkg::POS_CHANNEL) begin
					chan_d = byte_value;
				end else if (idx_q == mphd_pkg::POS_TYPE) begin
					if (byte_value[7:4] > 4'(mphd_pkg::MEDIA_PASS)) begin
						is_error = 1'b1;
						res_d.error_code = mphd_pkg::ERR_DATATYPE;
					end else if (byte_value[3:0] > 4'd3) begin
						is_error = 1'b1;
						res_d.error_code = mphd_pkg::ERR_SUBPACK;
					end else begin
						kind_d  = byte_value[6:4];
						frag_d  = byte_value[1:0];
						stamp_d = '0;
						len_d   = '0;
					end
				end else if (idx_q >= 5'(mphd_pkg::FIXED_PART)) begin
					// Video and audio shift their eight timestamp bytes into the stamp; length bytes stay out.
					if (kind_q <= mphd_pkg::MEDIA_AUDIO && idx_q < 5'(mphd_pkg::STAMP_END)) begin
						stamp_d = {stamp_q[55:0], byte_value};
					end
					if (idx_q == len_pos) begin
						len_d = {8'd0, byte_value};
					end else if (idx_q == len_pos + 5'd1) begin
						len_d = len_full;
						if (len_full > max_len_q) begin
							is_error = 1'b1;
							res_d.error_code = mphd_pkg::ERR_LENGTH;
						end else begin
							advance  = 1'b0;
							emit     = 1'b1;
							res_d.result_kind = mphd_pkg::RES_HEADER;
							remain_d = len_full;
							idx_d    = 5'd0;
							mark_d   = '0;
							if (len_full == 16'd0) begin
								res_d.message_end = ends_msg;
								phase_d = mphd_pkg::PH_HUNT;
							end else begin
								phase_d = mphd_pkg::PH_BODY;
							end
						end
					end
				end
				if (advance) begin
					idx_d = ((idx_q >= 5'(mphd_pkg::HEADER_BYTES)) ?
						5'(mphd_pkg::HEADER_BYTES - 1) : idx_q) + 5'd1;
				end
			end
			default: begin
				// Hunt: collect four bytes without sliding, then check the mark.
				mark_d = mark_full[23:0];
				if (hunt_idx < 5'd3) begin
					idx_d = hunt_idx + 5'd1;
				end else if (mark_full != mphd_pkg::MARK_WORD) begin
					is_error = 1'b1;
					res_d.error_code = mphd_pkg::ERR_MARK;
				end else begin
					phase_d = mphd_pkg::PH_HEADER;
					idx_d   = 5'd4;
				end
			end
		endcase

		if (is_error) begin
			// Drop the packet and hunt again.
			emit    = 1'b1;
			res_d.result_kind = mphd_pkg::RES_ERROR;
			phase_d = mphd_pkg::PH_HUNT;
			idx_d   = 5'd0;
			mark_d  = '0;
		end else if (emit) begin
			res_d.sequence_number = seq_d;
			res_d.channel_number  = chan_d;
			res_d.sim_number      = sim_d;
			res_d.media_kind      = kind_d;
			res_d.fragment_mark   = frag_d;
			res_d.codec_kind      = codec_d;
			res_d.time_stamp      = stamp_d;
			res_d.body_length     = len_d;
		end
	end

	// Control state and holds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= mphd_pkg::PH_HUNT;
			idx_q       <= '0;
			mark_q      <= '0;
			seq_q       <= '0;
			chan_q      <= '0;
			sim_q       <= '0;
			kind_q      <= '0;
			frag_q      <= '0;
			codec_q     <= '0;
			stamp_q     <= '0;
			len_q       <= '0;
			remain_q    <= '0;
			max_len_q   <= mphd_pkg::MAX_BODY_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_len_q <= max_body_length;
			end
			if (accept) begin
				phase_q  <= phase_d;
				idx_q    <= idx_d;
				mark_q   <= mark_d;
				seq_q    <= seq_d;
				chan_q   <= chan_d;
				sim_q    <= sim_d;
				kind_q   <= kind_d;
				frag_q   <= frag_d;
				codec_q  <= codec_d;
				stamp_q  <= stamp_d;
				len_q    <= len_d;
				remain_q <= remain_d;
			end
			// Advance the result register; it is empty or drains whenever a word is taken.
			if (accept) begin
				out_valid_q <= emit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: hold while stalled.
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			res_q <= res_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign result_kind     = res_q.result_kind;
	assign sequence_number = res_q.sequence_number;
	assign channel_number  = res_q.channel_number;
	assign sim_number      = res_q.sim_number;
	assign media_kind      = res_q.media_kind;
	assign fragment_mark   = res_q.fragment_mark;
	assign codec_kind      = res_q.codec_kind;
	assign time_stamp      = res_q.time_stamp;
	assign body_length     = res_q.body_length;
	assign body_byte       = res_q.body_byte;
	assign message_end     = res_q.message_end;
	assign error_code      = res_q.error_code;

endmodule
